### sv/hrf_pkg.sv
// hrf_pkg: shared types, constants and helper functions of the response framer
// no dependencies; used by the core and the top level
`default_nettype none

package hrf_pkg;

   // default counter width for content length and chunk size
   localparam int LENGTH_BITS_DEF = 40;

   typedef enum logic [8:0] {
      PH_STATUS  = 9'b000000001,
      PH_HEADER  = 9'b000000010,
      PH_CSIZE   = 9'b000000100,
      PH_CDATA   = 9'b000001000,
      PH_CEND    = 9'b000010000,
      PH_TRAILER = 9'b000100000,
      PH_LBODY   = 9'b001000000,
      PH_CBODY   = 9'b010000000,
      PH_ERROR   = 9'b100000000
   } phase_type;

   // header line kinds
   localparam logic [2:0] K_OTHER = 3'd0;
   localparam logic [2:0] K_PCONN = 3'd1;
   localparam logic [2:0] K_PCLEN = 3'd2;
   localparam logic [2:0] K_PTE   = 3'd3;
   localparam logic [2:0] K_CONNV = 3'd4;
   localparam logic [2:0] K_TEV   = 3'd5;
   localparam logic [2:0] K_CLPRE = 3'd6;
   localparam logic [2:0] K_CLDIG = 3'd7;

   // status line kinds
   localparam logic [2:0] LK_VER   = 3'd0;
   localparam logic [2:0] LK_MINOR = 3'd1;
   localparam logic [2:0] LK_CODE  = 3'd2;
   localparam logic [2:0] LK_TAIL  = 3'd3;

   // chunk size line kinds
   localparam logic [2:0] LK_HEX = 3'd0;
   localparam logic [2:0] LK_EXT = 3'd1;

   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_NUL = 8'h00;

   localparam int STR_BYTES = 18;
   localparam logic [8*STR_BYTES-1:0] VER_TEXT = "HTTP/1.";
   localparam logic [8*STR_BYTES-1:0] PFX_CONN = "connection:";
   localparam logic [8*STR_BYTES-1:0] PFX_CLEN = "content-length:";
   localparam logic [8*STR_BYTES-1:0] PFX_TE   = "transfer-encoding:";
   localparam int VER_LEN  = 7;
   localparam int CONN_LEN = 11;
   localparam int CLEN_LEN = 15;
   localparam int TE_LEN   = 18;

   localparam logic [8*5-1:0]  W_CLOSE   = "close";
   localparam logic [8*10-1:0] W_KEEP    = "keep-alive";
   localparam logic [8*7-1:0]  W_CHUNKED = "chunked";

   localparam logic [9:0] ST_MIN   = 10'd100;
   localparam logic [9:0] ST_INFO  = 10'd199;
   localparam logic [9:0] ST_MAX   = 10'd599;
   localparam logic [9:0] ST_OK    = 10'd200;
   localparam logic [9:0] ST_NOBDY = 10'd204;
   localparam logic [9:0] ST_NOMOD = 10'd304;
   localparam logic [9:0] ST_SAT   = 10'd1000;

   typedef struct packed {
      phase_type   phase;
      logic [9:0]  status_value;
      logic [4:0]  column;
      logic [2:0]  line_kind;
      logic [79:0] tail_window;   // newest byte in the low byte
      logic        chunked_mode;
      logic        have_length;
      logic        keep_alive_flag;
      logic        pipeline_flag;
      logic        prev_cr;
      logic        line_nonempty;
   } ctl_state_type;

   localparam ctl_state_type CTL_RESET = '{phase: PH_STATUS, default: '0};

   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_valid;
      logic       body_keep;
      logic       msg_done;
      logic       msg_error;
      logic [9:0] status_code;
      logic       keep_alive;
      logic       pipelined_ok;
   } rsp_type;

   function automatic logic [7:0] lower(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic logic is_dig(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   // character at position col of a right-aligned string of n characters
   function automatic logic [7:0] str_at(input logic [8*STR_BYTES-1:0] s, input int n,
                                         input logic [4:0] col);
      int idx;
      idx = 8 * (n - 1 - int'(col));
      if (idx < 0) idx = 0;
      return s[idx +: 8];
   endfunction

endpackage

`default_nettype wire

### sv/hrf_if.sv
// hrf_req_if and hrf_rsp_if: valid/ready channels of the response framer
// depends on nothing but the handshake convention
`default_nettype none

interface hrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       conn_closed;
   modport source (output valid, rx_byte, conn_closed, input ready);
   modport sink   (input valid, rx_byte, conn_closed, output ready);
endinterface

interface hrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       body_valid;
   logic       body_keep;
   logic       msg_done;
   logic       msg_error;
   logic [9:0] status_code;
   logic       keep_alive;
   logic       pipelined_ok;
   modport source (output valid, body_byte, body_valid, body_keep, msg_done, msg_error,
                   status_code, keep_alive, pipelined_ok, input ready);
   modport sink   (input valid, body_byte, body_valid, body_keep, msg_done, msg_error,
                   status_code, keep_alive, pipelined_ok, output ready);
endinterface

`default_nettype wire

### sv/hrf_core.sv
// hrf_core: next-state and result logic for one received item
// depends on hrf_pkg
`default_nettype none

module hrf_core #(
   parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEF
) (
   input  hrf_pkg::ctl_state_type  cur_ctl,
   input  logic [LENGTH_BITS-1:0]  cur_lc,
   input  logic [LENGTH_BITS-1:0]  cur_rem,
   input  logic [7:0]              rx_byte,
   input  logic                    conn_closed,
   output hrf_pkg::ctl_state_type  nxt_ctl,
   output logic [LENGTH_BITS-1:0]  nxt_lc,
   output logic [LENGTH_BITS-1:0]  nxt_rem,
   output hrf_pkg::rsp_type        res,
   output logic                    res_vld
);

   localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam logic [LENGTH_BITS-1:0] LIM10 = LENGTH_BITS'(LEN_MAX / 64'd10);
   localparam logic [LENGTH_BITS-1:0] LIM16 = LENGTH_BITS'(LEN_MAX / 64'd16);

   hrf_pkg::ctl_state_type s;
   logic [LENGTH_BITS-1:0] lc;
   logic [LENGTH_BITS-1:0] rem;
   logic                   fl;
   logic [1:0]             le;

   function automatic hrf_pkg::rsp_type mk_res(input hrf_pkg::ctl_state_type st,
                                               input logic [7:0] b, input logic v,
                                               input logic d, input logic e);
      hrf_pkg::rsp_type o;
      o.body_byte    = v ? b : 8'h00;
      o.body_valid   = v;
      o.body_keep    = (st.status_value == hrf_pkg::ST_OK);
      o.msg_done     = d;
      o.msg_error    = e;
      o.status_code  = st.status_value;
      o.keep_alive   = st.keep_alive_flag;
      o.pipelined_ok = st.pipeline_flag;
      return o;
   endfunction

   function automatic void new_line(inout hrf_pkg::ctl_state_type st);
      st.column        = '0;
      st.line_kind     = hrf_pkg::K_OTHER;
      st.line_nonempty = 1'b0;
      st.prev_cr       = 1'b0;
   endfunction

   function automatic void end_message(inout hrf_pkg::ctl_state_type st,
                                       inout logic [LENGTH_BITS-1:0] l,
                                       inout logic [LENGTH_BITS-1:0] r);
      logic p;
      p  = st.pipeline_flag;
      st = hrf_pkg::CTL_RESET;
      st.pipeline_flag = p;
      l  = '0;
      r  = '0;
   endfunction

   // walks a header name; 1 when its last character matched
   function automatic logic prefix_step(inout hrf_pkg::ctl_state_type st,
                                        input logic [8*hrf_pkg::STR_BYTES-1:0] p,
                                        input int n, input logic [7:0] c);
      if (int'(st.column) >= n || hrf_pkg::str_at(p, n, st.column) != c) begin
         st.line_kind = hrf_pkg::K_OTHER;
         return 1'b0;
      end
      return int'(st.column) == n - 1;
   endfunction

   // one content byte of a line; 1 on error
   function automatic logic content_fn(inout hrf_pkg::ctl_state_type st,
                                       inout logic [LENGTH_BITS-1:0] l,
                                       input logic [7:0] b);
      logic [7:0]  c;
      logic [13:0] v;
      logic [3:0]  hv;
      logic        hit;
      c   = hrf_pkg::lower(b);
      v   = '0;
      hv  = '0;
      hit = 1'b0;
      if (b == hrf_pkg::CH_NUL) begin
         st.phase = hrf_pkg::PH_ERROR;
         return 1'b1;
      end
      case (st.phase)
         hrf_pkg::PH_STATUS: begin
            if (st.line_kind == hrf_pkg::LK_VER) begin
               if (int'(st.column) < hrf_pkg::VER_LEN) begin
                  if (b != hrf_pkg::str_at(hrf_pkg::VER_TEXT, hrf_pkg::VER_LEN, st.column))
                  begin
                     st.phase = hrf_pkg::PH_ERROR;
                     return 1'b1;
                  end
               end else begin
                  if (!hrf_pkg::is_dig(b)) begin
                     st.phase = hrf_pkg::PH_ERROR;
                     return 1'b1;
                  end
                  if (b != "0") st.pipeline_flag = 1'b1;
                  st.line_kind = hrf_pkg::LK_MINOR;
               end
            end else if (st.line_kind == hrf_pkg::LK_MINOR) begin
               if (b == hrf_pkg::CH_SP) st.line_kind = hrf_pkg::LK_CODE;
            end else if (st.line_kind == hrf_pkg::LK_CODE) begin
               if (hrf_pkg::is_dig(b)) begin
                  v = {4'b0, st.status_value} * 14'd10 + {6'b0, b - 8'h30};
                  st.status_value = (v > 14'd999) ? hrf_pkg::ST_SAT : v[9:0];
               end else begin
                  st.line_kind = hrf_pkg::LK_TAIL;
               end
            end
         end
         hrf_pkg::PH_HEADER: begin
            st.line_nonempty = 1'b1;
            if (st.column == '0) begin
               st.line_kind = (c == "c") ? hrf_pkg::K_PCONN :
                              (c == "t") ? hrf_pkg::K_PTE : hrf_pkg::K_OTHER;
            end else begin
               case (st.line_kind)
                  hrf_pkg::K_PCONN: begin
                     if (st.column == 5'd3 && c == "t") begin
                        st.line_kind = hrf_pkg::K_PCLEN;
                     end else begin
                        hit = prefix_step(st, hrf_pkg::PFX_CONN, hrf_pkg::CONN_LEN, c);
                        if (hit) begin
                           st.line_kind   = hrf_pkg::K_CONNV;
                           st.tail_window = '0;
                        end
                     end
                  end
                  hrf_pkg::K_PCLEN: begin
                     hit = prefix_step(st, hrf_pkg::PFX_CLEN, hrf_pkg::CLEN_LEN, c);
                     if (hit) begin
                        st.line_kind   = hrf_pkg::K_CLPRE;
                        st.have_length = 1'b1;
                        l              = '0;
                     end
                  end
                  hrf_pkg::K_PTE: begin
                     hit = prefix_step(st, hrf_pkg::PFX_TE, hrf_pkg::TE_LEN, c);
                     if (hit) begin
                        st.line_kind   = hrf_pkg::K_TEV;
                        st.tail_window = '0;
                     end
                  end
                  hrf_pkg::K_CONNV: begin
                     st.tail_window = {st.tail_window[71:0], c};
                     if (st.tail_window[39:0] == hrf_pkg::W_CLOSE) st.pipeline_flag = 1'b0;
                     if (st.tail_window == hrf_pkg::W_KEEP) st.keep_alive_flag = 1'b1;
                  end
                  hrf_pkg::K_TEV: begin
                     st.tail_window = {st.tail_window[71:0], c};
                     if (st.tail_window[55:0] == hrf_pkg::W_CHUNKED) st.chunked_mode = 1'b1;
                  end
                  hrf_pkg::K_CLPRE, hrf_pkg::K_CLDIG: begin
                     if (hrf_pkg::is_dig(b)) begin
                        if (l >= LIM10) begin
                           st.phase = hrf_pkg::PH_ERROR;
                           return 1'b1;
                        end
                        l = (l << 3) + (l << 1) + LENGTH_BITS'(b - 8'h30);
                        st.line_kind = hrf_pkg::K_CLDIG;
                     end else if (st.line_kind == hrf_pkg::K_CLDIG) begin
                        st.line_kind = hrf_pkg::K_OTHER;
                     end
                  end
                  default: ;
               endcase
            end
         end
         hrf_pkg::PH_CSIZE: begin
            if (st.line_kind == hrf_pkg::LK_HEX) begin
               if (hrf_pkg::is_dig(c)) begin
                  hv  = 4'(c - 8'h30);
                  hit = 1'b1;
               end else if (c >= "a" && c <= "f") begin
                  hv  = 4'(c - 8'h57);
                  hit = 1'b1;
               end else begin
                  st.line_kind = hrf_pkg::LK_EXT;
               end
               if (hit) begin
                  if (l >= LIM16) begin
                     st.phase = hrf_pkg::PH_ERROR;
                     return 1'b1;
                  end
                  l = {l[LENGTH_BITS-5:0], hv};
               end
            end
         end
         hrf_pkg::PH_TRAILER: st.line_nonempty = 1'b1;
         default: ;
      endcase
      if (st.column != 5'd31) st.column = st.column + 5'd1;
      return 1'b0;
   endfunction

   // CR LF seen; returns {finish, error}
   function automatic logic [1:0] line_end_fn(inout hrf_pkg::ctl_state_type st,
                                              inout logic [LENGTH_BITS-1:0] l,
                                              inout logic [LENGTH_BITS-1:0] r);
      logic       empty;
      logic [2:0] kind;
      empty = !st.line_nonempty;
      kind  = st.line_kind;
      new_line(st);
      case (st.phase)
         hrf_pkg::PH_STATUS: begin
            if (kind < hrf_pkg::LK_CODE || st.status_value < hrf_pkg::ST_MIN ||
                st.status_value > hrf_pkg::ST_MAX) begin
               st.phase = hrf_pkg::PH_ERROR;
               return 2'b01;
            end
            st.phase = hrf_pkg::PH_HEADER;
         end
         hrf_pkg::PH_HEADER: begin
            if (empty) begin
               if (st.status_value >= hrf_pkg::ST_MIN && st.status_value <= hrf_pkg::ST_INFO)
               begin
                  st.status_value = '0;
                  st.phase = hrf_pkg::PH_STATUS;
               end else if (st.status_value == hrf_pkg::ST_NOBDY ||
                            st.status_value == hrf_pkg::ST_NOMOD) begin
                  return 2'b10;
               end else if (st.chunked_mode) begin
                  l = '0;
                  st.phase = hrf_pkg::PH_CSIZE;
               end else if (st.have_length) begin
                  if (l == '0) return 2'b10;
                  r = l;
                  l = '0;
                  st.phase = hrf_pkg::PH_LBODY;
               end else begin
                  st.phase = hrf_pkg::PH_CBODY;
               end
            end
         end
         hrf_pkg::PH_CSIZE: begin
            if (l == '0) begin
               st.phase = hrf_pkg::PH_TRAILER;
            end else begin
               r = l;
               l = '0;
               st.phase = hrf_pkg::PH_CDATA;
            end
         end
         hrf_pkg::PH_CEND: st.phase = hrf_pkg::PH_CSIZE;
         hrf_pkg::PH_TRAILER: begin
            if (empty) return 2'b10;
         end
         default: ;
      endcase
      return 2'b00;
   endfunction

   always_comb begin
      s       = cur_ctl;
      lc      = cur_lc;
      rem     = cur_rem;
      res     = '0;
      res_vld = 1'b0;
      fl      = 1'b0;
      le      = 2'b00;
      if (conn_closed) begin
         if (s.phase == hrf_pkg::PH_CBODY) begin
            s.pipeline_flag = 1'b0;
            res     = mk_res(s, 8'h00, 1'b0, 1'b1, 1'b0);
            res_vld = 1'b1;
         end else if (!(s.phase == hrf_pkg::PH_ERROR ||
                        (s.phase == hrf_pkg::PH_STATUS && s.column == '0 && !s.prev_cr)))
         begin
            res     = mk_res(s, 8'h00, 1'b0, 1'b0, 1'b1);
            res_vld = 1'b1;
         end
         s   = hrf_pkg::CTL_RESET;
         lc  = '0;
         rem = '0;
      end else begin
         case (s.phase)
            hrf_pkg::PH_STATUS, hrf_pkg::PH_HEADER, hrf_pkg::PH_CSIZE,
            hrf_pkg::PH_CEND, hrf_pkg::PH_TRAILER: begin
               if (s.prev_cr && rx_byte == hrf_pkg::CH_LF) begin
                  le = line_end_fn(s, lc, rem);
                  if (le[0]) begin
                     res     = mk_res(s, 8'h00, 1'b0, 1'b0, 1'b1);
                     res_vld = 1'b1;
                  end else if (le[1]) begin
                     res     = mk_res(s, 8'h00, 1'b0, 1'b1, 1'b0);
                     res_vld = 1'b1;
                     end_message(s, lc, rem);
                  end
               end else begin
                  // a lone cr becomes line content first
                  if (s.prev_cr) begin
                     s.prev_cr = 1'b0;
                     fl = content_fn(s, lc, hrf_pkg::CH_CR);
                  end
                  if (!fl) begin
                     if (rx_byte == hrf_pkg::CH_CR) s.prev_cr = 1'b1;
                     else fl = content_fn(s, lc, rx_byte);
                  end
                  if (fl) begin
                     res     = mk_res(s, 8'h00, 1'b0, 1'b0, 1'b1);
                     res_vld = 1'b1;
                  end
               end
            end
            hrf_pkg::PH_CDATA: begin
               if (rem != '0) rem = rem - 1'b1;
               if (rem == '0) begin
                  s.phase = hrf_pkg::PH_CEND;
                  new_line(s);
               end
               res     = mk_res(s, rx_byte, 1'b1, 1'b0, 1'b0);
               res_vld = 1'b1;
            end
            hrf_pkg::PH_LBODY: begin
               if (rem != '0) rem = rem - 1'b1;
               res_vld = 1'b1;
               if (rem == '0) begin
                  res = mk_res(s, rx_byte, 1'b1, 1'b1, 1'b0);
                  end_message(s, lc, rem);
               end else begin
                  res = mk_res(s, rx_byte, 1'b1, 1'b0, 1'b0);
               end
            end
            hrf_pkg::PH_CBODY: begin
               res     = mk_res(s, rx_byte, 1'b1, 1'b0, 1'b0);
               res_vld = 1'b1;
            end
            default: ;
         endcase
      end
      nxt_ctl = s;
      nxt_lc  = lc;
      nxt_rem = rem;
   end

endmodule

`default_nettype wire

### sv/http_response_framer.sv
// result: an accepted item that gives a result loads the result register at the
//   edge that accepts it, and rsp valid rises with it
// throughput: one item per cycle; req ready stays high while the result register
//   is empty or being drained, stalling only behind an untaken result
// reset: synchronous, active high; clears framing state and the result valid flag
`default_nettype none

module http_response_framer #(
   parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   hrf_req_if.sink        req_chan,
   hrf_rsp_if.source      rsp_chan
);

   // framing state, updated once per accepted item
   hrf_pkg::ctl_state_type ctl_ff, ctl_in;
   logic [LENGTH_BITS-1:0] lc_ff, lc_in;    // content length / chunk size accumulator
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;  // body bytes still to come

   // result register
   hrf_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_vld_ff;
   logic             res_vld;
   logic             req_fire;

   // take a new item whenever the result slot is free or leaving this cycle
   assign req_chan.ready = !rsp_vld_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   hrf_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
      .cur_ctl     (ctl_ff),
      .cur_lc      (lc_ff),
      .cur_rem     (rem_ff),
      .rx_byte     (req_chan.rx_byte),
      .conn_closed (req_chan.conn_closed),
      .nxt_ctl     (ctl_in),
      .nxt_lc      (lc_in),
      .nxt_rem     (rem_in),
      .res         (rsp_in),
      .res_vld     (res_vld)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff     <= hrf_pkg::CTL_RESET;
         lc_ff      <= '0;
         rem_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            ctl_ff <= ctl_in;
            lc_ff  <= lc_in;
            rem_ff <= rem_in;
         end
         // items that give no result just free the slot
         if (req_fire) rsp_vld_ff <= res_vld;
         else if (rsp_chan.ready) rsp_vld_ff <= 1'b0;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_fire && res_vld) rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.body_byte    = rsp_ff.body_byte;
   assign rsp_chan.body_valid   = rsp_ff.body_valid;
   assign rsp_chan.body_keep    = rsp_ff.body_keep;
   assign rsp_chan.msg_done     = rsp_ff.msg_done;
   assign rsp_chan.msg_error    = rsp_ff.msg_error;
   assign rsp_chan.status_code  = rsp_ff.status_code;
   assign rsp_chan.keep_alive   = rsp_ff.keep_alive;
   assign rsp_chan.pipelined_ok = rsp_ff.pipelined_ok;

endmodule

`default_nettype wire

### sv/hrf_checker.sv
// hrf_checker: port-level assertions for the response framer, bound to the top level
// depends on http_response_framer port names
`default_nettype none

module hrf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] body_byte,
   input wire logic       body_valid,
   input wire logic       msg_done,
   input wire logic       msg_error,
   input wire logic [9:0] status_code
);

   // a stalled result holds its valid, body byte and status code
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(body_byte) && $stable(status_code))
      else $error("stalled result changed");

   a_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !body_valid |-> body_byte == 8'h00)
      else $error("body byte without body_valid");

   a_done_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(msg_done && msg_error) && !(body_valid && msg_error))
      else $error("error flagged with done or body byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind http_response_framer hrf_checker u_hrf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .body_byte   (rsp_chan.body_byte),
   .body_valid  (rsp_chan.body_valid),
   .msg_done    (rsp_chan.msg_done),
   .msg_error   (rsp_chan.msg_error),
   .status_code (rsp_chan.status_code)
);

`default_nettype wire
